>>> sv/assert_macros.svh
// Assertion macros used by the controller RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset
`define HPL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define HPL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hpl_pkg.sv
// Shared types, constants and tables of the haversine path length block
package hpl_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int DIV_STEPS    = 51;

    localparam logic [13:0] SPEED_RESET = 14'd500;

    localparam logic signed [34:0] TURN_UNITS = 35'sd3600000000;
    localparam logic signed [33:0] HALF_SCALE = 34'sd640511947;
    localparam logic signed [33:0] FULL_SCALE = 34'sd1281023894;
    localparam logic signed [33:0] DIST_SCALE = 34'sd2001508680;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_WRAP,
        OP_BAM_MUL,
        OP_ROT_INIT,
        OP_CORDIC_STEP,
        OP_ROT_STORE,
        OP_PROD_MUL,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_VEC_INIT,
        OP_SEG_MUL,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] idx;
        logic       vec;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic last;
        logic div_en;
    } sts_t;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic [29:0] atan_bam(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/haversine_path_length.sv
// Waypoint path length: each waypoint runs the sequence below, and a closing waypoint with
// nonzero speed that is not a list's first also runs the divide; a list's first waypoint skips
// the arithmetic. One waypoint in work at a time: the next transfer can follow once the result
// is registered; a stalled result holds the block in its last step.
// The sequence is built on the shared CORDIC unit (four rotations and one vectoring pass of
// 30 steps), the 31-step square root pair and the 51-step restoring divider. Reset (rst_n
// low, async) clears list state and sets speed to 500 cm/s.
module haversine_path_length #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    // waypoint channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [30:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic               last_point,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [30:0]        segment_distance,
    output logic [40:0]        path_length,
    output logic [39:0]        duration_ms,
    output logic               list_done,
    // speed register write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [13:0]        speed_cm_per_s
);

    // Controller issues one datapath command per cycle; datapath reports list status.
    hpl_pkg::cmd_t cmd;
    hpl_pkg::sts_t sts;

    // Speed writes are registered directly, so the register port never stalls a transfer.
    assign cfg_ready = 1'b1;

    // Sequencer: accept, angle wrap, four angle multiplies, CORDIC sin/cos,
    // haversine products, square roots, atan2 by vectoring, scale, total,
    // optional divide, then hand the result to the output register.
    hpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic, list state and output registers.
    hpl_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .latitude         (latitude),
        .longitude        (longitude),
        .last_point       (last_point),
        .cfg_valid        (cfg_valid),
        .speed_cm_per_s   (speed_cm_per_s),
        .segment_distance (segment_distance),
        .path_length      (path_length),
        .duration_ms      (duration_ms),
        .list_done        (list_done)
    );

endmodule

>>> sv/hpl_dp.sv
// Datapath: shared multiplier, CORDIC unit, square roots, divider, list state
module hpl_dp #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hpl_pkg::cmd_t       cmd,
    output hpl_pkg::sts_t       sts,
    input  logic signed [30:0]  latitude,
    input  logic signed [31:0]  longitude,
    input  logic                last_point,
    input  logic                cfg_valid,
    input  logic [13:0]         speed_cm_per_s,
    output logic [30:0]         segment_distance,
    output logic [40:0]         path_length,
    output logic [39:0]         duration_ms,
    output logic                list_done
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // list state
    logic signed [30:0] prev_lat_reg;
    logic signed [31:0] prev_lon_reg;
    logic               have_prev_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [40:0]        total_reg;
    logic [13:0]        speed_reg;

    // working registers
    logic signed [30:0] lat_reg;
    logic signed [31:0] lon_reg;
    logic               last_reg;
    logic [31:0]        u_reg   [4];
    logic [31:0]        bam_reg [4];
    logic [1:0]         q_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic signed [33:0] sc_reg  [4];
    logic signed [33:0] t1_reg, t2_reg, p_reg, t3_reg;
    logic [60:0]        v1_reg, v2_reg, r1_reg, r2_reg;
    logic [30:0]        seg_reg;
    logic [14:0]        rem_reg;
    logic [50:0]        dq_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p, mul_rnd;
    logic signed [33:0] dlat, dlon, xs, ys, at, s_val, c_val, z_init;
    logic [31:0]        rot_t;
    logic               sigma;
    logic signed [34:0] a_sum;
    logic [30:0]        a_cl, z_cl;
    logic [5:0]         sq_sh;
    logic [60:0]        sq_bit, sq_s1, sq_s2;
    logic [41:0]        tot_sum;
    logic [50:0]        tot_wide, tot_x1000;
    logic [14:0]        rem_t;
    logic               rem_ge;
    logic               last_eff;

    function automatic logic [31:0] wrap_turn(input logic signed [34:0] d);
        logic signed [34:0] r;
        if (d >= hpl_pkg::TURN_UNITS)
            r = d - hpl_pkg::TURN_UNITS;
        else if (d >= 35'sd0)
            r = d;
        else if (d >= -hpl_pkg::TURN_UNITS)
            r = d + hpl_pkg::TURN_UNITS;
        else
            r = d + hpl_pkg::TURN_UNITS + hpl_pkg::TURN_UNITS;
        return r[31:0];
    endfunction

    assign count_next = (count_reg < CNT_W'(MAX_POINTS)) ? count_reg + 1'b1 : count_reg;
    assign last_eff   = last_point || (count_next >= CNT_W'(MAX_POINTS));

    assign sts.have_prev = have_prev_reg;
    assign sts.last      = last_reg;
    assign sts.div_en    = last_reg && have_prev_reg && (speed_reg != 14'd0);

    assign dlat = $signed({{3{lat_reg[30]}}, lat_reg})
                - $signed({{3{prev_lat_reg[30]}}, prev_lat_reg});
    assign dlon = $signed({{2{lon_reg[31]}}, lon_reg})
                - $signed({{2{prev_lon_reg[31]}}, prev_lon_reg});

    // z clamped to [0, 1.0] in Q30
    always_comb
    begin
        if (cz_reg[33])
            z_cl = 31'd0;
        else if (cz_reg > 34'sd1073741824)
            z_cl = 31'd1073741824;
        else
            z_cl = cz_reg[30:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            hpl_pkg::OP_BAM_MUL:
            begin
                mul_a = $signed({2'b00, u_reg[cmd.idx[1:0]]});
                mul_b = cmd.idx[1] ? hpl_pkg::FULL_SCALE : hpl_pkg::HALF_SCALE;
            end
            hpl_pkg::OP_PROD_MUL:
            begin
                case (cmd.idx[1:0])
                    2'd0:
                    begin
                        mul_a = sc_reg[0];
                        mul_b = sc_reg[0];
                    end
                    2'd1:
                    begin
                        mul_a = sc_reg[1];
                        mul_b = sc_reg[1];
                    end
                    2'd2:
                    begin
                        mul_a = sc_reg[2];
                        mul_b = sc_reg[3];
                    end
                    default:
                    begin
                        mul_a = p_reg;
                        mul_b = t2_reg;
                    end
                endcase
            end
            hpl_pkg::OP_SEG_MUL:
            begin
                mul_a = $signed({3'b000, z_cl});
                mul_b = hpl_pkg::DIST_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_rnd = mul_p + 68'sd536870912;

    // CORDIC micro-rotation
    assign xs    = cx_reg >>> cmd.idx[4:0];
    assign ys    = cy_reg >>> cmd.idx[4:0];
    assign at    = $signed({4'b0000, hpl_pkg::atan_bam(cmd.idx[4:0])});
    assign sigma = cmd.vec ? cy_reg[33] : !cz_reg[33];

    assign rot_t  = bam_reg[cmd.idx[1:0]] + 32'h2000_0000;
    assign z_init = $signed({4'b0000, rot_t[29:0]}) - 34'sd536870912;

    // quadrant fold
    always_comb
    begin
        case (q_reg)
            2'd0:
            begin
                s_val = cy_reg;
                c_val = cx_reg;
            end
            2'd1:
            begin
                s_val = cx_reg;
                c_val = -cy_reg;
            end
            2'd2:
            begin
                s_val = -cy_reg;
                c_val = -cx_reg;
            end
            default:
            begin
                s_val = -cx_reg;
                c_val = cy_reg;
            end
        endcase
    end

    // haversine term a, clamped to [0, 1.0]
    assign a_sum = $signed({t1_reg[33], t1_reg}) + $signed({t3_reg[33], t3_reg});
    always_comb
    begin
        if (a_sum[34])
            a_cl = 31'd0;
        else if (a_sum > 35'sd1073741824)
            a_cl = 31'd1073741824;
        else
            a_cl = a_sum[30:0];
    end

    // bit-serial square roots, two in lockstep
    assign sq_sh  = 6'd60 - {cmd.idx[4:0], 1'b0};
    assign sq_bit = 61'd1 << sq_sh;
    assign sq_s1  = r1_reg + sq_bit;
    assign sq_s2  = r2_reg + sq_bit;

    assign tot_sum   = {1'b0, total_reg} + {11'd0, seg_reg};
    assign tot_wide  = {10'd0, total_reg};
    assign tot_x1000 = (tot_wide << 10) - (tot_wide << 4) - (tot_wide << 3);

    assign rem_t  = {rem_reg[13:0], dq_reg[50]};
    assign rem_ge = rem_t >= {1'b0, speed_reg};

    // list state and speed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
            speed_reg     <= hpl_pkg::SPEED_RESET;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                speed_reg <= speed_cm_per_s;
            case (cmd.op)
                hpl_pkg::OP_CAPTURE:
                begin
                    last_reg  <= last_eff;
                    count_reg <= last_eff ? '0 : count_next;
                end
                hpl_pkg::OP_ACCUM:
                    total_reg <= tot_sum[41] ? {41{1'b1}} : tot_sum[40:0];
                hpl_pkg::OP_FINISH:
                begin
                    if (last_reg)
                    begin
                        prev_lat_reg  <= '0;
                        prev_lon_reg  <= '0;
                        have_prev_reg <= 1'b0;
                        total_reg     <= '0;
                    end
                    else
                    begin
                        prev_lat_reg  <= lat_reg;
                        prev_lon_reg  <= lon_reg;
                        have_prev_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            hpl_pkg::OP_CAPTURE:
            begin
                lat_reg <= latitude;
                lon_reg <= longitude;
                seg_reg <= '0;
            end
            hpl_pkg::OP_WRAP:
            begin
                u_reg[0] <= wrap_turn({dlat[33], dlat});
                u_reg[1] <= wrap_turn({dlon[33], dlon});
                u_reg[2] <= wrap_turn({{4{prev_lat_reg[30]}}, prev_lat_reg});
                u_reg[3] <= wrap_turn({{4{lat_reg[30]}}, lat_reg});
            end
            hpl_pkg::OP_BAM_MUL:
                bam_reg[cmd.idx[1:0]] <= mul_rnd[61:30];
            hpl_pkg::OP_ROT_INIT:
            begin
                q_reg  <= rot_t[31:30];
                cx_reg <= hpl_pkg::CORDIC_GAIN;
                cy_reg <= '0;
                cz_reg <= z_init;
            end
            hpl_pkg::OP_CORDIC_STEP:
            begin
                if (sigma)
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
            end
            hpl_pkg::OP_ROT_STORE:
                sc_reg[cmd.idx[1:0]] <= cmd.idx[1] ? c_val : s_val;
            hpl_pkg::OP_PROD_MUL:
            begin
                case (cmd.idx[1:0])
                    2'd0:    t1_reg <= mul_p[63:30];
                    2'd1:    t2_reg <= mul_p[63:30];
                    2'd2:    p_reg  <= mul_p[63:30];
                    default: t3_reg <= mul_p[63:30];
                endcase
            end
            hpl_pkg::OP_SQRT_INIT:
            begin
                v1_reg <= {a_cl, 30'd0};
                v2_reg <= {31'd1073741824 - a_cl, 30'd0};
                r1_reg <= '0;
                r2_reg <= '0;
            end
            hpl_pkg::OP_SQRT_STEP:
            begin
                if (v1_reg >= sq_s1)
                begin
                    v1_reg <= v1_reg - sq_s1;
                    r1_reg <= (r1_reg >> 1) + sq_bit;
                end
                else
                    r1_reg <= r1_reg >> 1;
                if (v2_reg >= sq_s2)
                begin
                    v2_reg <= v2_reg - sq_s2;
                    r2_reg <= (r2_reg >> 1) + sq_bit;
                end
                else
                    r2_reg <= r2_reg >> 1;
            end
            hpl_pkg::OP_VEC_INIT:
            begin
                cx_reg <= $signed(r2_reg[33:0]);
                cy_reg <= $signed(r1_reg[33:0]);
                cz_reg <= '0;
            end
            hpl_pkg::OP_SEG_MUL:
                seg_reg <= mul_rnd[60:30];
            hpl_pkg::OP_DIV_INIT:
            begin
                dq_reg  <= tot_x1000;
                rem_reg <= '0;
            end
            hpl_pkg::OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? rem_t - {1'b0, speed_reg} : rem_t;
                dq_reg  <= {dq_reg[49:0], rem_ge};
            end
            hpl_pkg::OP_FINISH:
            begin
                segment_distance <= seg_reg;
                path_length      <= total_reg;
                list_done        <= last_reg;
                if (!sts.div_en)
                    duration_ms <= '0;
                else if (dq_reg[50:40] != 11'd0)
                    duration_ms <= {40{1'b1}};
                else
                    duration_ms <= dq_reg[39:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> sv/hpl_ctrl.sv
// Controller: sequences one waypoint through the datapath
`include "assert_macros.svh"

module hpl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  hpl_pkg::sts_t sts,
    output hpl_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_BAM,
        S_ROT_INIT,
        S_ROT,
        S_ROT_STORE,
        S_PROD,
        S_SQRT_INIT,
        S_SQRT,
        S_VEC_INIT,
        S_VEC,
        S_SEG,
        S_ACCUM,
        S_DIV_INIT,
        S_DIV,
        S_FIN
    } state_t;

    localparam logic [5:0] CORDIC_LAST = 6'(hpl_pkg::CORDIC_STEPS - 1);
    localparam logic [5:0] SQRT_LAST   = 6'(hpl_pkg::SQRT_STEPS - 1);
    localparam logic [5:0] DIV_LAST    = 6'(hpl_pkg::DIV_STEPS - 1);

    state_t     state_reg;
    logic [5:0] cnt_reg;
    logic [1:0] ang_reg;
    logic       out_valid_reg;
    logic       slot_free;
    logic       in_xfer;
    logic       fin_stall;
    logic       div_busy;
    logic       cordic_busy;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    assign in_xfer     = in_valid && in_ready;
    assign fin_stall   = (state_reg == S_FIN) && out_valid_reg && !out_ready;
    assign div_busy    = (state_reg == S_DIV) || (state_reg == S_DIV_INIT);
    assign cordic_busy = (state_reg == S_ROT) || (state_reg == S_VEC);

    always_comb
    begin
        cmd.idx = cnt_reg;
        cmd.vec = (state_reg == S_VEC);
        case (state_reg)
            S_IDLE:      cmd.op = in_valid ? hpl_pkg::OP_CAPTURE : hpl_pkg::OP_NONE;
            S_WRAP:      cmd.op = hpl_pkg::OP_WRAP;
            S_BAM:       cmd.op = hpl_pkg::OP_BAM_MUL;
            S_ROT_INIT:  cmd.op = hpl_pkg::OP_ROT_INIT;
            S_ROT:       cmd.op = hpl_pkg::OP_CORDIC_STEP;
            S_ROT_STORE: cmd.op = hpl_pkg::OP_ROT_STORE;
            S_PROD:      cmd.op = hpl_pkg::OP_PROD_MUL;
            S_SQRT_INIT: cmd.op = hpl_pkg::OP_SQRT_INIT;
            S_SQRT:      cmd.op = hpl_pkg::OP_SQRT_STEP;
            S_VEC_INIT:  cmd.op = hpl_pkg::OP_VEC_INIT;
            S_VEC:       cmd.op = hpl_pkg::OP_CORDIC_STEP;
            S_SEG:       cmd.op = hpl_pkg::OP_SEG_MUL;
            S_ACCUM:     cmd.op = hpl_pkg::OP_ACCUM;
            S_DIV_INIT:  cmd.op = hpl_pkg::OP_DIV_INIT;
            S_DIV:       cmd.op = hpl_pkg::OP_DIV_STEP;
            S_FIN:       cmd.op = slot_free ? hpl_pkg::OP_FINISH : hpl_pkg::OP_NONE;
            default:     cmd.op = hpl_pkg::OP_NONE;
        endcase
        // angle select for rotation setup and store
        if (state_reg == S_ROT_INIT || state_reg == S_ROT_STORE)
            cmd.idx = {4'd0, ang_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ang_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // new result wins over the transfer of the old one
            if (state_reg == S_FIN && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_WRAP;
                S_WRAP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= sts.have_prev ? S_BAM : S_FIN;
                end
                S_BAM:
                begin
                    if (cnt_reg == 6'd3)
                    begin
                        ang_reg   <= '0;
                        state_reg <= S_ROT_INIT;
                    end
                    cnt_reg <= (cnt_reg == 6'd3) ? '0 : cnt_reg + 1'b1;
                end
                S_ROT_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (cnt_reg == CORDIC_LAST)
                        state_reg <= S_ROT_STORE;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_ROT_STORE:
                begin
                    cnt_reg <= '0;
                    if (ang_reg == 2'd3)
                        state_reg <= S_PROD;
                    else
                    begin
                        ang_reg   <= ang_reg + 1'b1;
                        state_reg <= S_ROT_INIT;
                    end
                end
                S_PROD:
                begin
                    if (cnt_reg == 6'd3)
                        state_reg <= S_SQRT_INIT;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_SQRT_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == SQRT_LAST)
                        state_reg <= S_VEC_INIT;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_VEC_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_VEC;
                end
                S_VEC:
                begin
                    if (cnt_reg == CORDIC_LAST)
                        state_reg <= S_SEG;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_SEG:
                    state_reg <= S_ACCUM;
                S_ACCUM:
                    state_reg <= sts.div_en ? S_DIV_INIT : S_FIN;
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == DIV_LAST)
                        state_reg <= S_FIN;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_FIN:
                    if (slot_free)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `HPL_ASSERT_NEXT(a_accept_starts, in_xfer, state_reg == S_WRAP, "accept did not start work")
    `HPL_ASSERT_NEXT(a_result_held, fin_stall, state_reg == S_FIN && out_valid_reg, "result lost")
    `HPL_ASSERT_IMPL(a_div_only_when_due, div_busy, sts.div_en, "divider run without closing point")
    `HPL_ASSERT_IMPL(a_cordic_count, cordic_busy, cnt_reg <= CORDIC_LAST, "CORDIC step overrun")

endmodule
